>>> design/midi_note_event_parser_macros.svh
// Assertion helpers shared by the parser RTL.
`ifndef MIDI_NOTE_EVENT_PARSER_MACROS_SVH
`define MIDI_NOTE_EVENT_PARSER_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define MNEP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define MNEP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/mnep_pkg.sv
package mnep_pkg;

    localparam int MIDI_BYTE_W = 8;
    localparam int NOTE_W      = 7;

    // Status nibbles of the parsed message kinds
    localparam logic [3:0] STAT_NOTE_OFF = 4'h8;
    localparam logic [3:0] STAT_NOTE_ON  = 4'h9;
    localparam logic [3:0] STAT_CTRL     = 4'hB;
    localparam logic [3:0] STAT_PROG     = 4'hC;

    // Real-time bytes start here
    localparam logic [MIDI_BYTE_W-1:0] RT_MIN = 8'hF8;

    localparam logic EV_NOTE_ON  = 1'b0;
    localparam logic EV_NOTE_OFF = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              event_kind;
        logic [NOTE_W-1:0] note_number;
    } t_result;

endpackage

>>> design/mnep_in_if.sv
interface mnep_in_if;
    import mnep_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [MIDI_BYTE_W-1:0] midi_byte;

    modport source (output valid, output midi_byte, input ready);
    modport sink   (input valid, input midi_byte, output ready);
endinterface

>>> design/mnep_out_if.sv
interface mnep_out_if;
    import mnep_pkg::*;

    logic              valid;
    logic              ready;
    logic              event_kind;
    logic [NOTE_W-1:0] note_number;

    modport source (output valid, output event_kind, output note_number, input ready);
    modport sink   (input valid, input event_kind, input note_number, output ready);
endinterface

>>> design/midi_note_event_parser.sv
// MIDI note event parser. Takes one raw MIDI byte per item on i_midi and
// gives a note event on o_event when the second data byte of a note-off or
// note-on message arrives; running status is honoured, and a note-on with
// velocity zero comes out as note off (event_kind 1). Control and program
// changes are tracked but give nothing; other status bytes put the parser
// into ignore mode until the next recognised status. Real-time bytes
// (0xF8 and up) are dropped without touching the parser. Rate: one byte per
// clock sustained while the input is not stalled; each byte is held in the
// input register, and the event it completes is loaded from there into the
// result register, which offers it on o_event. The input side stalls only
// while a finished event waits in the result register and the byte behind
// it would make another.
`include "midi_note_event_parser_macros.svh"

module midi_note_event_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mnep_in_if.sink    i_midi,
    mnep_out_if.source o_event
);
    import mnep_pkg::*;

    // Input register
    logic                   r_s1_valid, n_s1_valid;
    logic [MIDI_BYTE_W-1:0] r_s1_byte;

    t_result w_res;
    logic    w_out_free;
    logic    w_s1_fire;
    logic    w_accept;

    // Bytes that make no event pass on even when the result register is full
    assign w_s1_fire    = r_s1_valid && (!w_res.valid || w_out_free);
    assign i_midi.ready = !r_s1_valid || w_s1_fire;
    assign w_accept     = i_midi.valid && i_midi.ready;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (w_accept) begin
            n_s1_valid = 1'b1;
        end else if (w_s1_fire) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
        if (w_accept) begin
            r_s1_byte <= i_midi.midi_byte;
        end
    end

    // Parser state and decode
    mnep_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_s1_fire),
        .i_byte  (r_s1_byte),
        .o_res   (w_res)
    );

    // Result register
    mnep_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_s1_fire && w_res.valid),
        .i_res   (w_res),
        .o_free  (w_out_free),
        .o_event (o_event)
    );

    `MNEP_ASSERT_NEXT(a_event_lands, i_clk, i_rst_n,
        w_s1_fire && w_res.valid, o_event.valid,
        "event lost on way to result register")
    `MNEP_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n,
        o_event.valid && !o_event.ready, !(w_s1_fire && w_res.valid),
        "waiting event overwritten")
    `MNEP_ASSERT_NOW(a_rise_from_fire, i_clk, i_rst_n,
        $rose(o_event.valid), $past(w_s1_fire && w_res.valid),
        "event appeared without a parsed byte")

endmodule

>>> design/mnep_core.sv
`include "midi_note_event_parser_macros.svh"

module mnep_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_fire,
    input  logic [mnep_pkg::MIDI_BYTE_W-1:0] i_byte,
    output mnep_pkg::t_result               o_res
);
    import mnep_pkg::*;

    typedef enum logic [2:0] {
        ST_IGNORE,
        ST_OFF1,
        ST_OFF2,
        ST_ON1,
        ST_ON2,
        ST_CTRL1,
        ST_CTRL2,
        ST_PROG
    } t_state;

    t_state            r_state, n_state;
    logic [NOTE_W-1:0] r_held, n_held;
    logic              w_rt;
    logic              w_status;

    assign w_rt     = (i_byte >= RT_MIN);
    assign w_status = i_byte[MIDI_BYTE_W-1];

    always_comb begin
        n_state = r_state;
        n_held  = r_held;
        o_res   = '0;
        if (!w_rt) begin
            if (w_status) begin
                // status byte: straight to first data byte of the new message
                unique case (i_byte[MIDI_BYTE_W-1 -: 4])
                    STAT_NOTE_OFF: n_state = ST_OFF1;
                    STAT_NOTE_ON:  n_state = ST_ON1;
                    STAT_CTRL:     n_state = ST_CTRL1;
                    STAT_PROG:     n_state = ST_PROG;
                    default:       n_state = ST_IGNORE;
                endcase
            end else begin
                unique case (r_state)
                    ST_OFF1: begin
                        n_held  = i_byte[NOTE_W-1:0];
                        n_state = ST_OFF2;
                    end
                    ST_OFF2: begin
                        o_res.valid       = 1'b1;
                        o_res.event_kind  = EV_NOTE_OFF;
                        o_res.note_number = r_held;
                        n_state           = ST_OFF1;
                    end
                    ST_ON1: begin
                        n_held  = i_byte[NOTE_W-1:0];
                        n_state = ST_ON2;
                    end
                    ST_ON2: begin
                        // zero velocity counts as note off
                        o_res.valid       = 1'b1;
                        o_res.event_kind  = (i_byte == '0) ? EV_NOTE_OFF : EV_NOTE_ON;
                        o_res.note_number = r_held;
                        n_state           = ST_ON1;
                    end
                    ST_CTRL1: begin
                        n_held  = i_byte[NOTE_W-1:0];
                        n_state = ST_CTRL2;
                    end
                    ST_CTRL2:  n_state = ST_CTRL1;
                    ST_PROG:   n_state = ST_PROG;
                    ST_IGNORE: n_state = ST_IGNORE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IGNORE;
            r_held  <= '0;
        end else if (i_fire) begin
            r_state <= n_state;
            r_held  <= n_held;
        end
    end

    `MNEP_ASSERT_NEXT(a_rt_keeps_state, i_clk, i_rst_n, i_fire && w_rt, $stable(r_state) && $stable(r_held), "real-time byte disturbed parser state")
    `MNEP_ASSERT_NOW(a_status_no_event, i_clk, i_rst_n, w_status, !o_res.valid, "status byte produced an event")
    `MNEP_ASSERT_NOW(a_event_from_note2, i_clk, i_rst_n, o_res.valid, r_state == ST_OFF2 || r_state == ST_ON2, "event outside second note data byte")

endmodule

>>> design/mnep_out_reg.sv
module mnep_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  mnep_pkg::t_result i_res,
    output logic              o_free,
    mnep_out_if.source        o_event
);
    import mnep_pkg::*;

    logic              r_valid, n_valid;
    logic              r_kind;
    logic [NOTE_W-1:0] r_note;

    assign o_free = !r_valid || o_event.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_event.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_load) begin
            r_kind <= i_res.event_kind;
            r_note <= i_res.note_number;
        end
    end

    assign o_event.valid       = r_valid;
    assign o_event.event_kind  = r_kind;
    assign o_event.note_number = r_note;

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
    import mnep_pkg::*;

    // Random part size, counted over bytes the parser acts on
    localparam int PARSED_ITEMS = 1600;
    // Hard stop, well above the slowest legal run
    localparam int TIMEOUT_TU   = 5_000_000;
    // Settling time with margin after the last predicted event is out
    localparam int SETTLE_CYC   = 20;

    typedef struct packed {
        logic [MIDI_BYTE_W-1:0] data;
        bit                     drain;   // hold this byte until all events are out
    } midi_item_t;

    typedef struct packed {
        logic              kind;
        logic [NOTE_W-1:0] note;
    } note_event_t;

    // Parser phase as tracked by the predictor. Status bytes land straight in
    // the first-data-byte phase of their message.
    typedef enum logic [2:0] {
        P_SKIP, P_OFF_KEY, P_OFF_VEL, P_ON_KEY, P_ON_VEL, P_CC_NUM, P_CC_VAL, P_PC_DATA
    } parse_phase_e;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mnep_in_if  midi_if();
    mnep_out_if event_if();

    midi_note_event_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_midi  (midi_if),
        .o_event (event_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    midi_item_t   midi_items[$];       // bytes waiting to be driven
    note_event_t  note_events_due[$];  // predicted events, oldest first

    parse_phase_e phase;
    logic [NOTE_W-1:0] key_latch;

    bit  hold_next;
    int  parsed_count;
    int  realtime_count;
    int  drain_pauses;
    int  bytes_taken;
    int  events_seen;
    int  note_on_seen;
    int  note_off_seen;
    int  mismatches;

    bit  midi_taken;       // byte accepted at the last rising edge
    bit  send_calm;        // stretch with no sender gaps
    bit  recv_calm;        // stretch with no receiver stalls
    int  send_gap;
    int  recv_stall;

    // -------------------------------------------------------------------------
    // Predictor: running-status parse of one byte; pushes a note event if the
    // byte completes a note message.
    // -------------------------------------------------------------------------
    function automatic void parse_midi_byte(input logic [MIDI_BYTE_W-1:0] b);
        note_event_t ev;
        // real-time bytes are dropped and leave the parse state untouched
        if (b >= RT_MIN) return;
        if (b[7]) begin
            // any status restarts parsing; a half message is dropped
            case (b[7:4])
                STAT_NOTE_OFF: phase = P_OFF_KEY;
                STAT_NOTE_ON:  phase = P_ON_KEY;
                STAT_CTRL:     phase = P_CC_NUM;
                STAT_PROG:     phase = P_PC_DATA;
                default:       phase = P_SKIP;
            endcase
            return;
        end
        case (phase)
            P_OFF_KEY: begin
                key_latch = b[NOTE_W-1:0];
                phase     = P_OFF_VEL;
            end
            P_OFF_VEL: begin
                ev.kind = EV_NOTE_OFF;
                ev.note = key_latch;
                note_events_due.push_back(ev);
                phase   = P_OFF_KEY;
            end
            P_ON_KEY: begin
                key_latch = b[NOTE_W-1:0];
                phase     = P_ON_VEL;
            end
            P_ON_VEL: begin
                // zero velocity on a note-on is a note off
                ev.kind = (b == '0) ? EV_NOTE_OFF : EV_NOTE_ON;
                ev.note = key_latch;
                note_events_due.push_back(ev);
                phase   = P_ON_KEY;
            end
            P_CC_NUM: begin
                // the controller number shares the key latch
                key_latch = b[NOTE_W-1:0];
                phase     = P_CC_VAL;
            end
            P_CC_VAL: phase = P_CC_NUM;
            default: ;  // program data and ignore mode keep their phase
        endcase
    endfunction

    // Mostly no gap, some short gaps, a few long; none in a calm stretch
    function automatic int pace_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    task automatic put_byte(input logic [MIDI_BYTE_W-1:0] b, input bit counts);
        midi_item_t it;
        it.data   = b;
        it.drain  = hold_next;
        hold_next = 1'b0;
        midi_items.push_back(it);
        if (counts) parsed_count++;
        if (b >= RT_MIN) realtime_count++;
    endtask

    // Data byte of a message, now and then with a real-time byte slipped in
    task automatic put_data(input logic [MIDI_BYTE_W-1:0] b);
        if ($urandom_range(0, 29) == 0)
            put_byte(8'($urandom_range(RT_MIN, 8'hFF)), 1'b0);
        put_byte(b, 1'b1);
    endtask

    function automatic logic [MIDI_BYTE_W-1:0] rand_data();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'h7F;
        return 8'($urandom_range(0, 127));
    endfunction

    function automatic logic [MIDI_BYTE_W-1:0] rand_velocity();
        if ($urandom_range(0, 4) == 0) return 8'h00;
        return rand_data();
    endfunction

    // -------------------------------------------------------------------------
    // Stimulus: directed opening, then random message streams
    // -------------------------------------------------------------------------
    initial begin
        int pick;
        int n;
        int next_drain;
        logic [MIDI_BYTE_W-1:0] st;

        i_rst_n        = 1'b0;
        midi_if.valid  = 1'b0;
        midi_if.midi_byte = '0;
        event_if.ready = 1'b0;

        // data bytes straight after reset fall into ignore mode
        put_byte(8'h00, 1'b1);
        put_byte(8'h7F, 1'b1);
        // plain note-on, then running status with zero velocity
        put_byte({STAT_NOTE_ON, 4'h0}, 1'b1);
        put_byte(8'h3C, 1'b1);
        put_byte(8'h64, 1'b1);
        put_byte(8'h3C, 1'b1);
        put_byte(8'h00, 1'b1);
        // note-off at the top channel and key, with a clock byte mid message
        put_byte({STAT_NOTE_OFF, 4'hF}, 1'b1);
        put_byte(8'h7F, 1'b1);
        put_byte(RT_MIN, 1'b0);
        put_byte(8'h7F, 1'b1);
        // new status cuts a half-received note-on short
        put_byte({STAT_NOTE_ON, 4'hA}, 1'b1);
        put_byte(8'h20, 1'b1);
        put_byte({STAT_NOTE_OFF, 4'h5}, 1'b1);
        put_byte(8'h00, 1'b1);
        put_byte(8'h01, 1'b1);
        // control and program change: parsed, no events; wait for a drain first
        hold_next = 1'b1;
        put_byte({STAT_CTRL, 4'h3}, 1'b1);
        put_byte(8'h07, 1'b1);
        put_byte(8'h64, 1'b1);
        put_byte({STAT_PROG, 4'h5}, 1'b1);
        put_byte(8'h10, 1'b1);
        put_byte(8'h11, 1'b1);
        // unparsed status kinds, then the last real-time code
        put_byte(8'hA0, 1'b1);
        put_byte(8'h10, 1'b1);
        put_byte(8'hF0, 1'b1);
        put_byte(8'h55, 1'b1);
        put_byte(8'hFF, 1'b0);

        parsed_count = 0;
        next_drain   = 400;
        while (parsed_count < PARSED_ITEMS) begin
            if (parsed_count >= next_drain) begin
                hold_next  = 1'b1;
                next_drain += 400;
            end
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                // note message with a run of key/velocity pairs
                st = {(pick < 20) ? STAT_NOTE_OFF : STAT_NOTE_ON, 4'($urandom_range(0, 15))};
                put_byte(st, 1'b1);
                n = $urandom_range(1, 4);
                repeat (n) begin
                    put_data(rand_data());
                    put_data(rand_velocity());
                end
            end else if (pick < 55) begin
                // bare running-status pair on whatever was last seen
                put_data(rand_data());
                put_data(rand_velocity());
            end else if (pick < 66) begin
                put_byte({STAT_CTRL, 4'($urandom_range(0, 15))}, 1'b1);
                n = $urandom_range(1, 3);
                repeat (n) begin
                    put_data(rand_data());
                    put_data(rand_data());
                end
            end else if (pick < 74) begin
                put_byte({STAT_PROG, 4'($urandom_range(0, 15))}, 1'b1);
                n = $urandom_range(1, 3);
                repeat (n) put_data(rand_data());
            end else if (pick < 84) begin
                // broken note message: key only, the next status cuts it
                st = {($urandom_range(0, 1) == 0) ? STAT_NOTE_OFF : STAT_NOTE_ON,
                      4'($urandom_range(0, 15))};
                put_byte(st, 1'b1);
                put_data(rand_data());
            end else if (pick < 92) begin
                // other status kinds; the data after them is simply ignored
                st = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'hA0, 8'hAF))
                                                 : 8'($urandom_range(8'hD0, 8'hF7));
                put_byte(st, 1'b1);
                n = $urandom_range(0, 3);
                repeat (n) put_byte(rand_data(), 1'b0);
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) put_byte(8'($urandom_range(0, 255)), 1'b1);
            end
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (midi_items.size() != 0 || midi_if.valid) @(posedge i_clk);
        while (note_events_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("parsed %0d bytes (%0d real-time), %0d drain pauses", bytes_taken,
                 realtime_count, drain_pauses);
        $display("checked %0d note events: %0d note on, %0d note off, %0d errors",
                 events_seen, note_on_seen, note_off_seen, mismatches);
        if (mismatches == 0 && note_events_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #(TIMEOUT_TU);
        $display("timeout with %0d bytes unsent and %0d events outstanding",
                 midi_items.size(), note_events_due.size());
        $display("simulation failed");
        $finish;
    end

    initial begin
        phase     = P_SKIP;
        key_latch = '0;
    end

    // -------------------------------------------------------------------------
    // Byte driver: changes on the falling edge, holds until taken
    // -------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            midi_if.valid <= 1'b0;
        end else if (midi_if.valid && !midi_taken) begin
            // item still on offer
        end else if (send_gap > 0) begin
            send_gap      <= send_gap - 1;
            midi_if.valid <= 1'b0;
        end else if (midi_items.size() != 0 && midi_items[0].drain &&
                     note_events_due.size() != 0) begin
            // pause until every predicted event has left the block
            midi_if.valid <= 1'b0;
        end else if (midi_items.size() != 0) begin
            if (midi_items[0].drain) drain_pauses++;
            midi_if.valid     <= 1'b1;
            midi_if.midi_byte <= midi_items[0].data;
            void'(midi_items.pop_front());
            send_gap <= pace_gap(send_calm);
            if ($urandom_range(0, 59) == 0) send_calm <= !send_calm;
        end else begin
            midi_if.valid <= 1'b0;
        end
    end

    // Event receiver back-pressure
    always @(negedge i_clk) begin
        if (recv_stall > 0) begin
            recv_stall     <= recv_stall - 1;
            event_if.ready <= 1'b0;
        end else begin
            event_if.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) recv_stall <= pace_gap(recv_calm);
            if ($urandom_range(0, 59) == 0) recv_calm <= !recv_calm;
        end
    end

    // -------------------------------------------------------------------------
    // Monitor: predict on each byte taken, check each event given
    // -------------------------------------------------------------------------
    always @(posedge i_clk) begin
        note_event_t want;
        midi_taken = 1'b0;
        if (i_rst_n) begin
            if (midi_if.valid && midi_if.ready) begin
                midi_taken = 1'b1;
                bytes_taken++;
                parse_midi_byte(midi_if.midi_byte);
            end
            if (event_if.valid && event_if.ready) begin
                events_seen++;
                if (event_if.event_kind == EV_NOTE_ON) note_on_seen++;
                else note_off_seen++;
                if (note_events_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected note event: kind %0d note %0d",
                                 event_if.event_kind, event_if.note_number);
                    mismatches++;
                end else begin
                    want = note_events_due.pop_front();
                    if (event_if.event_kind !== want.kind ||
                        event_if.note_number !== want.note) begin
                        if (mismatches < 10)
                            $display({"note event %0d: expected kind %0d note %0d, ",
                                      "got kind %0d note %0d"},
                                     events_seen, want.kind, want.note,
                                     event_if.event_kind, event_if.note_number);
                        mismatches++;
                    end
                end
            end
        end
    end

endmodule
